// ===== hw/rtl/mab_pkg.sv =====
// ----------------------------------------------------------------------------
// mab_pkg: shared types, tables and round functions
// Substitution tables, GF(2^8) helpers and the byte-level round steps used by
// the key schedule and by the round stages of the modified AES-128 core.
// ----------------------------------------------------------------------------
package mab_pkg;

  // default number of rounds
  localparam int unsigned RoundsDef = 10;
  // block and register widths
  localparam int unsigned BlkW = 128;
  localparam int unsigned CfgW = 64;
  localparam int unsigned CfgIdxW = 1;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_e;

  // control carried next to the data through the stages
  typedef struct packed {
    logic vld;
    logic mode;
  } ctl_t;

  // mode codes
  localparam logic ModeEnc = 1'b0;
  localparam logic ModeDec = 1'b1;

  // forward substitution table, entry 0 in the top byte
  localparam logic [2047:0] FwdBox = {
    128'h377c777bf26bf5c53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d386fbcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245c68d3ac629195e479,
    128'he7c8636d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe642c241992d0fb054bb16
  };

  // inverse substitution table, entry 0 in the top byte
  localparam logic [2047:0] InvBox = {
    128'h52096ad53036a538bf40a39e81f3d7fb,
    128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e,
    128'h082ea16628d92400765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692,
    128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8abb28cbcd30aa8e45805b8b34577,
    128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673,
    128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b,
    128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fddf7338807c731b11210592780ec5f,
    128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961,
    128'h172b047eba06d626e169146355210c7d
  };

  // field polynomial low byte
  localparam logic [7:0] GfPoly = 8'h1b;

  // table lookups
  function automatic logic [7:0] sbox_fwd(input logic [7:0] b);
    return FwdBox[{~b, 3'b111} -: 8];
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] b);
    return InvBox[{~b, 3'b111} -: 8];
  endfunction

  // prime round constants
  function automatic logic [7:0] prime_rc(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:    r = 8'h02;
      4'd1:    r = 8'h03;
      4'd2:    r = 8'h05;
      4'd3:    r = 8'h07;
      4'd4:    r = 8'h11;
      4'd5:    r = 8'h13;
      4'd6:    r = 8'h17;
      4'd7:    r = 8'h1d;
      4'd8:    r = 8'h1f;
      4'd9:    r = 8'h25;
      4'd10:   r = 8'h29;
      4'd11:   r = 8'h2b;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // substitute all four bytes of a word
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox_fwd(w[31:24]), sbox_fwd(w[23:16]), sbox_fwd(w[15:8]), sbox_fwd(w[7:0])};
  endfunction

  // multiply in GF(2^8), b is a constant at every use
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x = a;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) acc = acc ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ GfPoly) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

  // byte k of the state, byte 0 on top; s[4c+r] is row r of column c
  function automatic logic [7:0] st_byte(input logic [BlkW-1:0] s, input int k);
    return s[BlkW-1-8*k -: 8];
  endfunction

  function automatic logic [BlkW-1:0] sub_state(input logic [BlkW-1:0] s, input logic inv);
    logic [BlkW-1:0] t;
    t = '0;
    for (int k = 0; k < 16; k++) begin
      t[BlkW-1-8*k -: 8] = inv ? sbox_inv(st_byte(s, k)) : sbox_fwd(st_byte(s, k));
    end
    return t;
  endfunction

  function automatic logic [BlkW-1:0] shift_state(input logic [BlkW-1:0] s, input logic inv);
    logic [BlkW-1:0] t;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[BlkW-1-8*(4*c+r) -: 8] = inv ? st_byte(s, 4*((c - r + 4) & 3) + r)
                                       : st_byte(s, 4*((c + r) & 3) + r);
      end
    end
    return t;
  endfunction

  function automatic logic [BlkW-1:0] mix_cols(input logic [BlkW-1:0] s, input logic inv);
    logic [BlkW-1:0] t;
    logic [7:0] v;
    logic [7:0] m [4];
    t = '0;
    if (inv) begin
      m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
    end else begin
      m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) begin
          v = v ^ gf_mul(st_byte(s, 4*c+k), m[(k - r + 4) & 3]);
        end
        t[BlkW-1-8*(4*c+r) -: 8] = v;
      end
    end
    return t;
  endfunction

endpackage

// ===== hw/rtl/mab_in_if.sv =====
// ----------------------------------------------------------------------------
// mab_in_if: block input channel
// Valid/ready channel carrying the mode and one 128-bit block per item.
// ----------------------------------------------------------------------------
interface mab_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] block_high;
  logic [63:0] block_low;

  modport source (output valid, output mode, output block_high, output block_low,
                  input ready);
  modport sink (input valid, input mode, input block_high, input block_low,
                output ready);
endinterface

// ===== hw/rtl/mab_out_if.sv =====
// ----------------------------------------------------------------------------
// mab_out_if: block result channel
// Valid/ready channel carrying one 128-bit result per item.
// ----------------------------------------------------------------------------
interface mab_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;

  modport source (output valid, output result_high, output result_low, input ready);
  modport sink (input valid, input result_high, input result_low, output ready);
endinterface

// ===== hw/rtl/modified_aes128_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// modified_aes128_block_cipher_core: pipelined modified AES-128 block cipher
// ECB encrypt/decrypt of one 128-bit block per item with a custom S-box and a
// modified key schedule; one round per pipeline stage.
//
//   port        dir   kind        content
//   blk_in      in    valid/rdy   mode, block_high, block_low
//   blk_out     out   valid/rdy   result_high, result_low
//   cfg_*       in    write port  key_high (index 0), key_low (index 1)
//
// One item per cycle while the output is not stalled and the key bank is ready;
// a key add stage, then ROUNDS round stages, the last of which is the output register.
// After reset and after every key write the key schedule runs one word per
// cycle, with blk_in.ready low.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// fill up and a stalled output holds every item in place.
// ----------------------------------------------------------------------------
module modified_aes128_block_cipher_core #(
  parameter int unsigned ROUNDS = mab_pkg::RoundsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mab_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mab_pkg::CfgW-1:0]    cfg_data_i,
  mab_in_if.sink                      blk_in,
  mab_out_if.source                   blk_out
);

  localparam int unsigned NumWords = 4 * (ROUNDS + 1);

  logic [31:0]              rk [NumWords];
  logic                     keys_rdy;
  logic                     en [ROUNDS+1];
  mab_pkg::ctl_t            ctl [ROUNDS+1];
  logic [mab_pkg::BlkW-1:0] st [ROUNDS+1];
  mab_pkg::ctl_t            ctl0_q;
  logic [mab_pkg::BlkW-1:0] st0_q;
  logic [mab_pkg::BlkW-1:0] st0_d;
  logic                     in_acc;

  // key registers and schedule
  mab_key_exp #(
    .ROUNDS(ROUNDS)
  ) u_key_exp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .rk_o      (rk),
    .ready_o   (keys_rdy)
  );

  // stage enables, from the output back to the input
  always_comb begin
    en[ROUNDS] = !ctl[ROUNDS].vld || blk_out.ready;
    for (int k = ROUNDS - 1; k >= 0; k--) begin
      en[k] = !ctl[k].vld || en[k+1];
    end
  end

  assign blk_in.ready = en[0] && keys_rdy;
  assign in_acc = blk_in.valid && blk_in.ready;

  // initial key add: round key 0 to encrypt, the last round key to decrypt
  always_comb begin
    if (blk_in.mode == mab_pkg::ModeDec) begin
      st0_d = {blk_in.block_high, blk_in.block_low} ^
              {rk[4*ROUNDS], rk[4*ROUNDS+1], rk[4*ROUNDS+2], rk[4*ROUNDS+3]};
    end else begin
      st0_d = {blk_in.block_high, blk_in.block_low} ^ {rk[0], rk[1], rk[2], rk[3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else if (en[0]) begin
      ctl0_q.vld <= in_acc;
      ctl0_q.mode <= blk_in.mode;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) st0_q <= st0_d;
  end

  assign ctl[0] = ctl0_q;
  assign st[0] = st0_q;

  // round stages
  for (genvar j = 1; j <= ROUNDS; j++) begin : g_round
    mab_round #(
      .ROUNDS(ROUNDS),
      .STAGE (j)
    ) u_round (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en[j]),
      .ctl_i    (ctl[j-1]),
      .state_i  (st[j-1]),
      .enc_key_i({rk[4*j], rk[4*j+1], rk[4*j+2], rk[4*j+3]}),
      .dec_key_i({rk[4*(ROUNDS-j)], rk[4*(ROUNDS-j)+1],
                  rk[4*(ROUNDS-j)+2], rk[4*(ROUNDS-j)+3]}),
      .ctl_o    (ctl[j]),
      .state_o  (st[j])
    );
  end

  // output channel is the last stage
  assign blk_out.valid = ctl[ROUNDS].vld;
  assign blk_out.result_high = st[ROUNDS][127:64];
  assign blk_out.result_low = st[ROUNDS][63:0];

  // an accepted item lands in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ctl[0].vld)
    else $error("accepted item missing from first stage");

  // no item is taken while the key bank is being built
  a_key_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !keys_rdy |-> !blk_in.ready)
    else $error("item accepted during key schedule");

  // a held output keeps the stage before it from moving when that one is full
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blk_out.valid && !blk_out.ready && ctl[ROUNDS-1].vld) |-> !en[ROUNDS-1])
    else $error("stage overwritten during stall");

  // a key write drops the key bank ready
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !keys_rdy)
    else $error("key bank still ready after key write");

endmodule

// ===== hw/rtl/mab_key_exp.sv =====
// ----------------------------------------------------------------------------
// mab_key_exp: key registers and key schedule
// Holds the two key registers and expands them one word per cycle into the
// round key bank after reset and after every key write.
// ----------------------------------------------------------------------------
module mab_key_exp #(
  parameter int unsigned ROUNDS = mab_pkg::RoundsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mab_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mab_pkg::CfgW-1:0]    cfg_data_i,
  output logic [31:0]                 rk_o [4*(ROUNDS+1)],
  output logic                        ready_o
);

  localparam int unsigned NumWords = 4 * (ROUNDS + 1);
  localparam int unsigned CntW = $clog2(NumWords + 1);

  logic [mab_pkg::BlkW-1:0] key_q;
  logic                     ready_q;
  logic [CntW-1:0]          cnt_q;
  logic [1:0]               m3_q;
  logic [31:0]              win_q [4];
  logic [31:0]              rk_q [NumWords];
  logic                     busy;
  logic                     load;
  logic [3:0]               rc_idx;
  logic [31:0]              t;
  logic [31:0]              sw;
  logic [31:0]              nw;

  assign busy = !ready_q && !cfg_we_i;
  assign load = busy && (cnt_q == '0);

  // next schedule word from the four-word window
  always_comb begin
    rc_idx = 4'((cnt_q >> 2) - 1'b1);
    t = win_q[3];
    sw = mab_pkg::sub_word(t);
    if (cnt_q[1:0] == 2'd0) begin
      t = mab_pkg::sub_word({win_q[3][23:0], win_q[3][31:24]}) ^
          {mab_pkg::prime_rc(rc_idx), 24'h000000};
    end else if (cnt_q[1:0] == 2'd2) begin
      t = {sw[31:16], win_q[3][15:0]};
    end else if (m3_q == 2'd0) begin
      t = {win_q[3][7:0], win_q[3][31:8]};
    end
    nw = win_q[0] ^ t;
  end

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      case (mab_pkg::cfg_reg_e'(cfg_idx_i))
        mab_pkg::REG_KEY_HIGH: key_q[127:64] <= cfg_data_i;
        mab_pkg::REG_KEY_LOW:  key_q[63:0] <= cfg_data_i;
        default:               key_q <= key_q;
      endcase
    end
  end

  // schedule control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      cnt_q <= '0;
      m3_q <= 2'd0;
    end else if (cfg_we_i) begin
      ready_q <= 1'b0;
      cnt_q <= '0;
    end else if (!ready_q) begin
      if (cnt_q == '0) begin
        cnt_q <= CntW'(4);
        m3_q <= 2'd1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
        m3_q <= (m3_q == 2'd2) ? 2'd0 : m3_q + 2'd1;
        if (cnt_q == CntW'(NumWords - 1)) ready_q <= 1'b1;
      end
    end
  end

  // window and round key bank
  always_ff @(posedge clk_i) begin
    if (load) begin
      win_q[0] <= key_q[127:96];
      win_q[1] <= key_q[95:64];
      win_q[2] <= key_q[63:32];
      win_q[3] <= key_q[31:0];
    end else if (busy) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= nw;
    end
    for (int j = 0; j < NumWords; j++) begin
      if (j < 4) begin
        if (load) rk_q[j] <= key_q[127-32*(j & 3) -: 32];
      end else if (busy && (cnt_q == CntW'(j))) begin
        rk_q[j] <= nw;
      end
    end
  end

  assign rk_o = rk_q;
  assign ready_o = ready_q;

  // schedule counter stays within the bank, parking one past its end
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(NumWords))
    else $error("key schedule counter out of range");

  // a key write restarts the schedule
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (!ready_q && cnt_q == '0))
    else $error("key write did not restart the schedule");

  // the bank turns ready only after its last word
  a_ready_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> ($past(cnt_q) == CntW'(NumWords - 1)))
    else $error("key bank ready too early");

endmodule

// ===== hw/rtl/mab_round.sv =====
// ----------------------------------------------------------------------------
// mab_round: one cipher round stage
// Computes one encryption or decryption round, chosen per item, and registers
// the state with its control; the last stage skips the column mix.
// ----------------------------------------------------------------------------
module mab_round #(
  parameter int unsigned ROUNDS = mab_pkg::RoundsDef,
  parameter int unsigned STAGE  = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  mab_pkg::ctl_t            ctl_i,
  input  logic [mab_pkg::BlkW-1:0] state_i,
  input  logic [mab_pkg::BlkW-1:0] enc_key_i,
  input  logic [mab_pkg::BlkW-1:0] dec_key_i,
  output mab_pkg::ctl_t            ctl_o,
  output logic [mab_pkg::BlkW-1:0] state_o
);

  localparam bit LastRound = (STAGE == ROUNDS);

  mab_pkg::ctl_t            ctl_q;
  logic [mab_pkg::BlkW-1:0] state_q;
  logic [mab_pkg::BlkW-1:0] enc_sh;
  logic [mab_pkg::BlkW-1:0] enc_st;
  logic [mab_pkg::BlkW-1:0] dec_sb;
  logic [mab_pkg::BlkW-1:0] dec_st;
  logic [mab_pkg::BlkW-1:0] state_d;

  // round datapath for both directions
  always_comb begin
    enc_sh = mab_pkg::shift_state(mab_pkg::sub_state(state_i, 1'b0), 1'b0);
    enc_st = (LastRound ? enc_sh : mab_pkg::mix_cols(enc_sh, 1'b0)) ^ enc_key_i;
    dec_sb = mab_pkg::sub_state(mab_pkg::shift_state(state_i, 1'b1), 1'b1) ^ dec_key_i;
    dec_st = LastRound ? dec_sb : mab_pkg::mix_cols(dec_sb, 1'b1);
    state_d = (ctl_i.mode == mab_pkg::ModeDec) ? dec_st : enc_st;
  end

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (en_i) state_q <= state_d;
  end

  assign ctl_o = ctl_q;
  assign state_o = state_q;

endmodule

// ===== sim/mab_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mab_tb_pkg: block cipher prediction for the testbench
// Independent model of the modified AES-128 core: key schedule with prime
// round constants and the encrypt/decrypt round sequence on 128-bit blocks.
// ----------------------------------------------------------------------------
package mab_tb_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumWords = 4 * (NumRounds + 1);

  typedef logic [7:0] byte_t;
  typedef byte_t state_t [16];

  // forward substitution table
  localparam byte_t SubTab [256] = '{
    8'h37,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'hf5,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'h6f,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'h68,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h63,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'hc2,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // inverse substitution table
  localparam byte_t UnsubTab [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'h00,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'hb2,8'h8c,8'hbc,8'hd3,8'h0a,8'ha8,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h77,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'hf7,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h06,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam byte_t PrimeRcon [12] = '{8'h02, 8'h03, 8'h05, 8'h07, 8'h11, 8'h13,
                                       8'h17, 8'h1d, 8'h1f, 8'h25, 8'h29, 8'h2b};

  function automatic byte_t gmul(byte_t a, byte_t b);
    byte_t acc;
    acc = 8'h00;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) acc ^= a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    end
    return acc;
  endfunction

  function automatic logic [31:0] subst_word(logic [31:0] w);
    return {SubTab[w[31:24]], SubTab[w[23:16]], SubTab[w[15:8]], SubTab[w[7:0]]};
  endfunction

  // key schedule with prime round constants and partial substitution
  function automatic void expand_key(input logic [63:0] kh, input logic [63:0] kl,
                                     output logic [31:0] rk [NumWords]);
    logic [31:0] t;
    rk[0] = kh[63:32]; rk[1] = kh[31:0]; rk[2] = kl[63:32]; rk[3] = kl[31:0];
    for (int i = 4; i < NumWords; i++) begin
      t = rk[i-1];
      if (i % 4 == 0) begin
        t = subst_word({t[23:0], t[31:24]}) ^ {PrimeRcon[((i / 4) - 1) % 12], 24'h0};
      end else if (i % 2 == 0) begin
        t = {subst_word(t) & 32'hffff0000} | (t & 32'h0000ffff);
      end else if (i % 3 == 0) begin
        t = {t[7:0], t[31:8]};
      end
      rk[i] = rk[i-4] ^ t;
    end
  endfunction

  function automatic void key_xor(ref state_t s, input logic [31:0] rk [NumWords],
                                  input int rnd);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) s[4*c+r] ^= rk[4*rnd+c][31-8*r -: 8];
  endfunction

  function automatic void shift_and_sub(ref state_t s, input bit inverse);
    state_t t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[4*c+r] = s[4*(inverse ? ((c - r + 4) & 3) : ((c + r) & 3)) + r];
    for (int k = 0; k < 16; k++) s[k] = inverse ? UnsubTab[t[k]] : SubTab[t[k]];
  endfunction

  function automatic void mix_state(ref state_t s, input bit inverse);
    byte_t m [4];
    byte_t col [4];
    byte_t v;
    if (inverse) begin
      m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
    end else begin
      m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) col[r] = s[4*c+r];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= gmul(m[(k - r + 4) & 3], col[k]);
        s[4*c+r] = v;
      end
    end
  endfunction

  // full block transform; decrypt when dec is set
  function automatic logic [127:0] cipher_block(input logic [31:0] rk [NumWords],
                                                input logic dec, input logic [127:0] blk);
    state_t s;
    logic [127:0] res;
    for (int k = 0; k < 16; k++) s[k] = blk[127-8*k -: 8];
    if (!dec) begin
      key_xor(s, rk, 0);
      for (int rnd = 1; rnd < NumRounds; rnd++) begin
        shift_and_sub(s, 1'b0);
        mix_state(s, 1'b0);
        key_xor(s, rk, rnd);
      end
      shift_and_sub(s, 1'b0);
      key_xor(s, rk, NumRounds);
    end else begin
      key_xor(s, rk, NumRounds);
      for (int rnd = NumRounds - 1; rnd > 0; rnd--) begin
        shift_and_sub(s, 1'b1);
        key_xor(s, rk, rnd);
        mix_state(s, 1'b1);
      end
      shift_and_sub(s, 1'b1);
      key_xor(s, rk, 0);
    end
    for (int k = 0; k < 16; k++) res[127-8*k -: 8] = s[k];
    return res;
  endfunction

endpackage

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the modified AES-128 core
// Drives key writes and blocks over valid/ready, predicts every result with
// an independent cipher model and compares results in order, with random
// stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  mab_pkg::cfg_reg_e cfg_idx_i;
  logic [mab_pkg::CfgW-1:0] cfg_data_i;

  mab_in_if blk_in ();
  mab_out_if blk_out ();

  modified_aes128_block_cipher_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .blk_in    (blk_in.sink),
    .blk_out   (blk_out.source)
  );

  logic [63:0] key_hi, key_lo;
  logic [31:0] round_keys [mab_tb_pkg::NumWords];
  logic [127:0] pending_blocks [$];
  int send_idle_pct, recv_idle_pct;
  int mismatches;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result checker with random back-pressure
  initial begin
    logic [127:0] want;
    blk_out.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (blk_out.valid && blk_out.ready) begin
        if (pending_blocks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item %h_%h", blk_out.result_high, blk_out.result_low);
        end else begin
          want = pending_blocks.pop_front();
          if ({blk_out.result_high, blk_out.result_low} !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result: expected %h got %h_%h", want,
                       blk_out.result_high, blk_out.result_low);
          end
        end
      end
      blk_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one key write, then the write enable drops and the model round keys are recomputed
  task automatic write_key(mab_pkg::cfg_reg_e idx, logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == mab_pkg::REG_KEY_HIGH) key_hi = val;
    else key_lo = val;
    mab_tb_pkg::expand_key(key_hi, key_lo, round_keys);
  endtask

  // send one block and queue its predicted result; valid stays up for the next
  task automatic send_block(logic dec, logic [63:0] hi, logic [63:0] lo);
    while ($urandom_range(99) < send_idle_pct) begin
      blk_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    blk_in.valid <= 1'b1;
    blk_in.mode <= dec;
    blk_in.block_high <= hi;
    blk_in.block_low <= lo;
    pending_blocks.push_back(mab_tb_pkg::cipher_block(round_keys, dec, {hi, lo}));
    do @(posedge clk_i); while (!blk_in.ready);
  endtask

  task automatic drain();
    blk_in.valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed_blocks();
    send_block(mab_pkg::ModeEnc, 64'h0, 64'h0);
    send_block(mab_pkg::ModeDec, 64'h0, 64'h0);
    send_block(mab_pkg::ModeEnc, '1, '1);
    send_block(mab_pkg::ModeDec, '1, '1);
    send_block(mab_pkg::ModeEnc, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(mab_pkg::ModeDec, 64'h8000000000000000, 64'h0000000000000001);
    for (int b = 0; b < 8; b++) send_block(b[0], 64'h1 << (8 * b), ~(64'h1 << (63 - b)));
  endtask

  task automatic test_key_extremes();
    write_key(mab_pkg::REG_KEY_HIGH, '1);
    write_key(mab_pkg::REG_KEY_LOW, '1);
    send_block(mab_pkg::ModeEnc, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(mab_pkg::ModeDec, 64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();
    write_key(mab_pkg::REG_KEY_LOW, 64'h0);
    send_block(mab_pkg::ModeEnc, '1, 64'h0);
    send_block(mab_pkg::ModeDec, 64'h0, '1);
    drain();
  endtask

  // random keys and blocks, each block in a random mode, with a new key half every 100 blocks
  task automatic test_random_blocks(int count);
    logic [63:0] hi, lo;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        drain();
        if ($urandom_range(1)) write_key(mab_pkg::REG_KEY_HIGH, rand64());
        else write_key(mab_pkg::REG_KEY_LOW, rand64());
      end
      hi = rand64();
      lo = rand64();
      send_block(1'($urandom_range(1)), hi, lo);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = mab_pkg::REG_KEY_HIGH;
    cfg_data_i = '0;
    blk_in.valid = 1'b0;
    blk_in.mode = mab_pkg::ModeEnc;
    blk_in.block_high = '0;
    blk_in.block_low = '0;
    key_hi = '0;
    key_lo = '0;
    mismatches = 0;
    send_idle_pct = 9;
    recv_idle_pct = 59;
    mab_tb_pkg::expand_key(key_hi, key_lo, round_keys);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_blocks();
    drain();
    test_key_extremes();
    test_random_blocks(400);
    drain();
    send_idle_pct = 59;
    recv_idle_pct = 9;
    test_random_blocks(400);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_blocks(400);
    drain();
    if (mismatches == 0) $display("modified_aes128_block_cipher_core: match");
    else $display("modified_aes128_block_cipher_core: mismatch");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("modified_aes128_block_cipher_core: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mab_pkg.sv
hw/rtl/mab_in_if.sv
hw/rtl/mab_out_if.sv
hw/rtl/mab_key_exp.sv
hw/rtl/mab_round.sv
hw/rtl/modified_aes128_block_cipher_core.sv
sim/mab_tb_pkg.sv
sim/testbench.sv
